// ===== hdl/cpt_pkg.sv =====
// Shared types and constants for the closest-point-on-triangle pipeline.
// Used by the top level, the multiplier, the checker and the testbench.
package cpt_pkg;

  localparam int CRD_W   = 32;              // coordinate word width
  localparam int DIG_W   = 32;              // multiplier digit width
  localparam int MUL_LAT = 5;               // cpt_mul register stages

  localparam int DIF_W   = CRD_W + 1;       // vertex differences
  localparam int PRD_W   = 2 * DIF_W;       // one product of two differences
  localparam int DOT_W   = PRD_W + 2;       // three-term dot product
  localparam int VP_W    = 2 * DOT_W;       // product of two dot products
  localparam int V_W     = VP_W + 1;        // region determinants va, vb, vc
  localparam int DEN_W   = V_W + 2;         // barycentric denominator
  localparam int NP_W    = DIF_W + V_W;     // direction times weight
  localparam int NUM_W   = NP_W + 1;        // offset numerator
  localparam int QB_W    = CRD_W + 2;       // quotient bits kept before saturation
  localparam int DIV_LAT = QB_W + 1;        // cpt_div register stages

  // pipeline stage of each register rank, input register is stage 0
  localparam int S_DIF   = 1;
  localparam int S_DOT   = S_DIF + MUL_LAT + 1;
  localparam int S_V     = S_DOT + MUL_LAT + 1;
  localparam int S_SEL   = S_V + 1;
  localparam int S_DEN   = S_SEL + 1;
  localparam int S_NSUM  = S_SEL + MUL_LAT + 1;
  localparam int S_NMAG  = S_NSUM + 1;
  localparam int S_NDIV  = S_NMAG + 1;
  localparam int S_QS    = S_NDIV + DIV_LAT + 1;
  localparam int S_OUT   = S_QS + 1;
  localparam int CPT_LAT = S_OUT + 1;       // accept edge to strobe sample edge

  typedef struct packed {
    logic signed [CRD_W-1:0] query_x;
    logic signed [CRD_W-1:0] query_y;
    logic signed [CRD_W-1:0] query_z;
    logic signed [CRD_W-1:0] vert_a_x;
    logic signed [CRD_W-1:0] vert_a_y;
    logic signed [CRD_W-1:0] vert_a_z;
    logic signed [CRD_W-1:0] vert_b_x;
    logic signed [CRD_W-1:0] vert_b_y;
    logic signed [CRD_W-1:0] vert_b_z;
    logic signed [CRD_W-1:0] vert_c_x;
    logic signed [CRD_W-1:0] vert_c_y;
    logic signed [CRD_W-1:0] vert_c_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] near_x;
    logic signed [CRD_W-1:0] near_y;
    logic signed [CRD_W-1:0] near_z;
  } out_word_t;

endpackage

// ===== hdl/cpt_mul.sv =====
// Pipelined signed multiplier built from DIG_W x DIG_W digit products.
// Five register stages: magnitude, digit products, row sums, total, sign.
// Depends on cpt_pkg.
module cpt_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import cpt_pkg::*;

  localparam int NA = (AW + DIG_W - 1) / DIG_W;
  localparam int NB = (BW + DIG_W - 1) / DIG_W;
  localparam int PW = AW + BW;
  localparam int SW = (NA + NB) * DIG_W;

  logic [AW-1:0]         ma_c;
  logic [BW-1:0]         mb_c;
  logic [NA*DIG_W-1:0]   ma_r;
  logic [NB*DIG_W-1:0]   mb_r;
  logic [3:0]            ng_r;
  logic [2*DIG_W-1:0]    pp_r [NA][NB];
  logic [SW-1:0]         row_c [NA];
  logic [SW-1:0]         row_r [NA];
  logic [SW-1:0]         tot_c;
  logic [SW-1:0]         tot_r;
  logic signed [PW-1:0]  p_r;

  assign ma_c = a[AW-1] ? AW'(-a) : AW'(a);
  assign mb_c = b[BW-1] ? BW'(-b) : BW'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_c[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_c[i] = row_c[i] + (SW'(pp_r[i][j]) << (j * DIG_W));
      end
    end
    tot_c = '0;
    for (int i = 0; i < NA; i++) begin
      tot_c = tot_c + (row_r[i] << (i * DIG_W));
    end
  end

  always_ff @(posedge clk) begin
    ma_r <= (NA*DIG_W)'(ma_c);
    mb_r <= (NB*DIG_W)'(mb_c);
    ng_r <= {ng_r[2:0], a[AW-1] ^ b[BW-1]};
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= ma_r[i*DIG_W +: DIG_W] * mb_r[j*DIG_W +: DIG_W];
      end
    end
    row_r <= row_c;
    tot_r <= tot_c;
    p_r   <= ng_r[3] ? -$signed(tot_r[PW-1:0]) : $signed(tot_r[PW-1:0]);
  end

  assign p = p_r;

endmodule

// ===== hdl/cpt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// A quotient that does not fit in QB bits comes out as all ones.
// Does not import cpt_pkg; its widths come in as parameters.
module cpt_div #(
  parameter int NW = 173,
  parameter int DW = 140,
  parameter int QB = 34
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  localparam int RW = DW + 1;
  localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [RW-1:0] rem_r [QB+1];
  logic [QB-1:0] lo_r  [QB+1];
  logic [DW-1:0] dv_r  [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic [QB:0]   ovf_r;

  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(num >> QB);
    lo_r[0]  <= num[QB-1:0];
    dv_r[0]  <= den;
    q_r[0]   <= '0;
    ovf_r[0] <= CW'(num) >= (CW'(den) << QB);
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [RW-1:0] t_w;
    logic          ge_w;
    assign t_w  = {rem_r[k-1][RW-2:0], lo_r[k-1][QB-k]};
    assign ge_w = t_w >= RW'(dv_r[k-1]);
    always_ff @(posedge clk) begin
      rem_r[k] <= ge_w ? t_w - RW'(dv_r[k-1]) : t_w;
      lo_r[k]  <= lo_r[k-1];
      dv_r[k]  <= dv_r[k-1];
      q_r[k]   <= {q_r[k-1][QB-2:0], ge_w};
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign quo = ovf_r[QB] ? '1 : q_r[QB];

endmodule

// ===== hdl/closest_point_on_triangle.sv =====
// Closest point on a triangle, fully pipelined: one word accepted per cycle.
// The result strobe's delay is set by three rounds of wide multiplies (5 stages
// each) and the 35-stage divider, plus the registers between them.
// busy is always low; results cannot be held off and leave one per strobe.
// Synchronous active-low reset clears the valid pipeline only.
module closest_point_on_triangle (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cpt_pkg::in_word_t  in_word,
  output logic               busy,
  output logic               out_strobe,
  output cpt_pkg::out_word_t out_word
);
  import cpt_pkg::*;

  typedef logic signed [CRD_W-1:0]   crd_t;
  typedef logic signed [DIF_W-1:0]   dif_t;
  typedef logic signed [PRD_W-1:0]   prd_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [DOT_W:0]     e_t;
  typedef logic signed [VP_W-1:0]    vp_t;
  typedef logic signed [V_W-1:0]     v_t;
  typedef logic signed [DEN_W-1:0]   den_t;
  typedef logic signed [NP_W-1:0]    np_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic signed [QB_W:0]      qs_t;
  typedef logic signed [QB_W+1:0]    rs_t;

  typedef enum logic [2:0] {
    RG_A, RG_B, RG_C, RG_AB, RG_AC, RG_BC, RG_FACE
  } region_t;

  localparam int N1 = S_V;
  localparam int N2 = S_V - S_DIF;
  localparam int N3 = S_V - S_DOT;
  localparam int N4 = S_NMAG - S_DEN + 1;
  localparam int N5 = DIV_LAT;
  localparam int NPR_W = NUM_W + 2;
  localparam int DPR_W = DEN_W + 1;
  localparam int VL [6] = '{0, 2, 4, 0, 2, 4};
  localparam int VR [6] = '{3, 1, 1, 5, 5, 3};
  localparam crd_t CMAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam crd_t CMIN = {1'b1, {(CRD_W-1){1'b0}}};

  logic [S_OUT:0] vld_r;

  // stage 0: p, a, b, c
  crd_t in_v_r [4][3];
  // differences ab, ac, ap, bp, cp, bc
  dif_t ab_r [3], ac_r [3], ap_r [3], bp_r [3], cp_r [3], bc_r [3];
  prd_t dprod [6][3];
  dot_t dot_r [6];
  vp_t  vprod [6];
  v_t   va_r, vb_r, vc_r;
  e_t   e1_r, e2_r;
  logic fa_r, fb_r, fc_r;

  crd_t vx_d_r [1:N1][3][3];
  dif_t df_d_r [1:N2][3][3];
  dot_t dd_r   [1:N3][6];
  dot_t dm [6];
  dot_t ds [6];

  region_t rg_c;
  logic    no_off_c;
  crd_t    st_c [3];
  dif_t    mu_c [3], mw_c [3];
  v_t      mx_c, my_c;
  den_t    den_c;

  logic    no_off_r;
  crd_t    st_r [3];
  dif_t    mu_r [3], mw_r [3];
  v_t      mx_r, my_r;
  den_t    den_r;

  np_t     pu [3], pw [3];
  num_t    nsum_r [3];
  logic [2:0]       nneg_r;
  logic [NUM_W-1:0] nmag_r [3];

  crd_t             st4_r [1:N4][3];
  logic [N4:1]      no4_r;
  logic [N4:1]      dn4_r;
  logic [DEN_W-1:0] dm4_r [1:N4];

  logic [NPR_W-1:0] npr_r [3];
  logic [DPR_W-1:0] dpr_r;
  logic [2:0]       qneg_r;
  crd_t             st6_r [3];
  logic             no6_r;
  logic [QB_W-1:0]  quo [3];

  crd_t             st5_r [1:N5][3];
  logic [N5:1]      no5_r;
  logic [2:0]       qn5_r [1:N5];

  qs_t              qs_r [3];
  crd_t             stq_r [3];
  logic             noq_r;
  crd_t             res_c [3];
  out_word_t        out_word_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[S_OUT-1:0], start};
    end
  end

  // input register and differences
  always_ff @(posedge clk) begin
    in_v_r[0][0] <= in_word.query_x;
    in_v_r[0][1] <= in_word.query_y;
    in_v_r[0][2] <= in_word.query_z;
    in_v_r[1][0] <= in_word.vert_a_x;
    in_v_r[1][1] <= in_word.vert_a_y;
    in_v_r[1][2] <= in_word.vert_a_z;
    in_v_r[2][0] <= in_word.vert_b_x;
    in_v_r[2][1] <= in_word.vert_b_y;
    in_v_r[2][2] <= in_word.vert_b_z;
    in_v_r[3][0] <= in_word.vert_c_x;
    in_v_r[3][1] <= in_word.vert_c_y;
    in_v_r[3][2] <= in_word.vert_c_z;
    for (int i = 0; i < 3; i++) begin
      ab_r[i] <= dif_t'(in_v_r[2][i]) - dif_t'(in_v_r[1][i]);
      ac_r[i] <= dif_t'(in_v_r[3][i]) - dif_t'(in_v_r[1][i]);
      ap_r[i] <= dif_t'(in_v_r[0][i]) - dif_t'(in_v_r[1][i]);
      bp_r[i] <= dif_t'(in_v_r[0][i]) - dif_t'(in_v_r[2][i]);
      cp_r[i] <= dif_t'(in_v_r[0][i]) - dif_t'(in_v_r[3][i]);
      bc_r[i] <= dif_t'(in_v_r[3][i]) - dif_t'(in_v_r[2][i]);
    end
  end

  // d1..d6: {ab,ac} against {ap,bp,cp}
  for (genvar k = 0; k < 6; k++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_ax
      dif_t l_w, r_w;
      assign l_w = (k % 2 == 0) ? ab_r[i] : ac_r[i];
      assign r_w = (k / 2 == 0) ? ap_r[i] : ((k / 2 == 1) ? bp_r[i] : cp_r[i]);
      cpt_mul #(.AW(DIF_W), .BW(DIF_W)) u_mul (
        .clk(clk), .a(l_w), .b(r_w), .p(dprod[k][i])
      );
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      dot_r[k] <= dot_t'(dprod[k][0]) + dot_t'(dprod[k][1]) + dot_t'(dprod[k][2]);
    end
  end

  // vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
  for (genvar k = 0; k < 6; k++) begin : g_vmul
    cpt_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul (
      .clk(clk), .a(dot_r[VL[k]]), .b(dot_r[VR[k]]), .p(vprod[k])
    );
  end

  // delay lines for operands still needed at region select
  always_ff @(posedge clk) begin
    for (int v = 0; v < 3; v++) begin
      vx_d_r[1][v] <= in_v_r[v+1];
    end
    df_d_r[1][0] <= ab_r;
    df_d_r[1][1] <= ac_r;
    df_d_r[1][2] <= bc_r;
    dd_r[1]      <= dot_r;
    for (int j = 2; j <= N1; j++) vx_d_r[j] <= vx_d_r[j-1];
    for (int j = 2; j <= N2; j++) df_d_r[j] <= df_d_r[j-1];
    for (int j = 2; j <= N3; j++) dd_r[j]   <= dd_r[j-1];
  end

  assign dm = dd_r[N3-1];
  assign ds = dd_r[N3];

  always_ff @(posedge clk) begin
    vc_r <= v_t'(vprod[0]) - v_t'(vprod[1]);
    vb_r <= v_t'(vprod[2]) - v_t'(vprod[3]);
    va_r <= v_t'(vprod[4]) - v_t'(vprod[5]);
    e1_r <= e_t'(dm[3]) - e_t'(dm[2]);
    e2_r <= e_t'(dm[4]) - e_t'(dm[5]);
    fa_r <= (dm[0][DOT_W-1] || dm[0] == '0) && (dm[1][DOT_W-1] || dm[1] == '0);
    fb_r <= !dm[2][DOT_W-1] && (dm[3] <= dm[2]);
    fc_r <= !dm[5][DOT_W-1] && (dm[4] <= dm[5]);
  end

  // Voronoi region, in test order
  always_comb begin
    priority if (fa_r) begin
      rg_c = RG_A;
    end else if (fb_r) begin
      rg_c = RG_B;
    end else if ((vc_r[V_W-1] || vc_r == '0) && !ds[0][DOT_W-1]
                 && (ds[2][DOT_W-1] || ds[2] == '0)) begin
      rg_c = RG_AB;
    end else if (fc_r) begin
      rg_c = RG_C;
    end else if ((vb_r[V_W-1] || vb_r == '0) && !ds[1][DOT_W-1]
                 && (ds[5][DOT_W-1] || ds[5] == '0)) begin
      rg_c = RG_AC;
    end else if ((va_r[V_W-1] || va_r == '0) && !e1_r[DOT_W] && !e2_r[DOT_W]) begin
      rg_c = RG_BC;
    end else begin
      rg_c = RG_FACE;
    end
  end

  // offset = (u*x + w*y) / den, added to the start vertex
  always_comb begin
    no_off_c = 1'b0;
    st_c     = vx_d_r[N1][0];
    mx_c     = '0;
    my_c     = '0;
    den_c    = '0;
    for (int i = 0; i < 3; i++) begin
      mu_c[i] = '0;
      mw_c[i] = '0;
    end
    unique case (rg_c)
      RG_A: begin
        no_off_c = 1'b1;
      end
      RG_B: begin
        no_off_c = 1'b1;
        st_c     = vx_d_r[N1][1];
      end
      RG_C: begin
        no_off_c = 1'b1;
        st_c     = vx_d_r[N1][2];
      end
      RG_AB: begin
        mu_c  = df_d_r[N2][0];
        mx_c  = v_t'(ds[0]);
        den_c = den_t'(ds[0]) - den_t'(ds[2]);
      end
      RG_AC: begin
        mu_c  = df_d_r[N2][1];
        mx_c  = v_t'(ds[1]);
        den_c = den_t'(ds[1]) - den_t'(ds[5]);
      end
      RG_BC: begin
        st_c  = vx_d_r[N1][1];
        mu_c  = df_d_r[N2][2];
        mx_c  = v_t'(e1_r);
        den_c = den_t'(e1_r) + den_t'(e2_r);
      end
      RG_FACE: begin
        mu_c  = df_d_r[N2][0];
        mw_c  = df_d_r[N2][1];
        mx_c  = vb_r;
        my_c  = vc_r;
        den_c = den_t'(va_r) + den_t'(vb_r) + den_t'(vc_r);
      end
      default: begin
        no_off_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    no_off_r <= no_off_c;
    st_r     <= st_c;
    mu_r     <= mu_c;
    mw_r     <= mw_c;
    mx_r     <= mx_c;
    my_r     <= my_c;
    den_r    <= den_c;
  end

  for (genvar i = 0; i < 3; i++) begin : g_nmul
    cpt_mul #(.AW(DIF_W), .BW(V_W)) u_mul_u (
      .clk(clk), .a(mu_r[i]), .b(mx_r), .p(pu[i])
    );
    cpt_mul #(.AW(DIF_W), .BW(V_W)) u_mul_w (
      .clk(clk), .a(mw_r[i]), .b(my_r), .p(pw[i])
    );
  end

  // denominator magnitude; a zero one leaves the start vertex
  always_ff @(posedge clk) begin
    st4_r[1] <= st_r;
    no4_r[1] <= no_off_r || (den_r == '0);
    dn4_r[1] <= den_r[DEN_W-1];
    dm4_r[1] <= den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);
    for (int j = 2; j <= N4; j++) begin
      st4_r[j] <= st4_r[j-1];
      no4_r[j] <= no4_r[j-1];
      dn4_r[j] <= dn4_r[j-1];
      dm4_r[j] <= dm4_r[j-1];
    end
  end

  // rounded quotient: (2|n| + |d|) / (2|d|)
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nsum_r[i] <= num_t'(pu[i]) + num_t'(pw[i]);
      nneg_r[i] <= nsum_r[i][NUM_W-1];
      nmag_r[i] <= nsum_r[i][NUM_W-1] ? NUM_W'(-nsum_r[i]) : NUM_W'(nsum_r[i]);
      npr_r[i]  <= NPR_W'({nmag_r[i], 1'b0}) + NPR_W'(dm4_r[N4]);
      qneg_r[i] <= nneg_r[i] ^ dn4_r[N4];
    end
    dpr_r <= {dm4_r[N4], 1'b0};
    st6_r <= st4_r[N4];
    no6_r <= no4_r[N4];
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    cpt_div #(.NW(NPR_W), .DW(DPR_W), .QB(QB_W)) u_div (
      .clk(clk), .num(npr_r[i]), .den(dpr_r), .quo(quo[i])
    );
  end

  always_ff @(posedge clk) begin
    st5_r[1] <= st6_r;
    no5_r[1] <= no6_r;
    qn5_r[1] <= qneg_r;
    for (int j = 2; j <= N5; j++) begin
      st5_r[j] <= st5_r[j-1];
      no5_r[j] <= no5_r[j-1];
      qn5_r[j] <= qn5_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      qs_r[i] <= qn5_r[N5][i] ? -qs_t'({1'b0, quo[i]}) : qs_t'({1'b0, quo[i]});
    end
    stq_r <= st5_r[N5];
    noq_r <= no5_r[N5];
  end

  // add to start vertex and saturate
  always_comb begin
    rs_t sum;
    for (int i = 0; i < 3; i++) begin
      sum = rs_t'(stq_r[i]) + rs_t'(qs_r[i]);
      priority if (noq_r) begin
        res_c[i] = stq_r[i];
      end else if (sum > rs_t'(CMAX)) begin
        res_c[i] = CMAX;
      end else if (sum < rs_t'(CMIN)) begin
        res_c[i] = CMIN;
      end else begin
        res_c[i] = crd_t'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r.near_x <= res_c[0];
    out_word_r.near_y <= res_c[1];
    out_word_r.near_z <= res_c[2];
  end

  assign out_strobe = vld_r[S_OUT];
  assign out_word   = out_word_r;

endmodule

// ===== hdl/cpt_chk.sv =====
// Port-level checker for closest_point_on_triangle, bound to the top level.
// Depends on cpt_pkg for the fixed pipeline latency.
module cpt_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);
  import cpt_pkg::*;

  // fully pipelined: never refuses a word
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every accepted word yields its result after the fixed latency
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##CPT_LAT out_strobe)
    else $error("result missing after accepted word");

  // no result without a word accepted the latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, CPT_LAT))
    else $error("result strobe without matching word");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");

endmodule

bind closest_point_on_triangle cpt_chk u_cpt_chk (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_strobe(out_strobe)
);

// ===== dv/closest_point_on_triangle_tb.sv =====
// Self-checking testbench for closest_point_on_triangle: directed and random
// point/triangle words, predicted with exact 256-bit arithmetic. Needs cpt_pkg.
module closest_point_on_triangle_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpt_pkg::*;

  typedef logic signed [255:0] big_t;

  class nearest_point_board;
    out_word_t pending[$];
    int unsigned n_checked;
    int unsigned n_bad;

    function big_t sat(big_t v);
      big_t hi, lo;
      hi = (big_t'(1) <<< (CRD_W - 1)) - 1;
      lo = -(big_t'(1) <<< (CRD_W - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // nearest integer, ties away from zero
    function big_t div_round(big_t n, big_t d);
      big_t mn, md, q;
      mn = n < 0 ? -n : n;
      md = d < 0 ? -d : d;
      q  = (2 * mn + md) / (2 * md);
      return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function big_t dot(big_t u[3], big_t v[3]);
      return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function out_word_t nearest(in_word_t w);
      big_t p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
      big_t st[3], dir[3], r[3];
      big_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, num, e1, e2;
      out_word_t o;
      int kind; // 0 vertex st, 1 edge, 2 face
      p = '{big_t'(w.query_x), big_t'(w.query_y), big_t'(w.query_z)};
      a = '{big_t'(w.vert_a_x), big_t'(w.vert_a_y), big_t'(w.vert_a_z)};
      b = '{big_t'(w.vert_b_x), big_t'(w.vert_b_y), big_t'(w.vert_b_z)};
      c = '{big_t'(w.vert_c_x), big_t'(w.vert_c_y), big_t'(w.vert_c_z)};
      for (int i = 0; i < 3; i++) begin
        ab[i] = b[i] - a[i]; ac[i] = c[i] - a[i]; ap[i] = p[i] - a[i];
        bp[i] = p[i] - b[i]; cp[i] = p[i] - c[i]; bc[i] = c[i] - b[i];
      end
      d1 = dot(ab, ap); d2 = dot(ac, ap);
      d3 = dot(ab, bp); d4 = dot(ac, bp);
      d5 = dot(ab, cp); d6 = dot(ac, cp);
      vc = d1 * d4 - d3 * d2;
      vb = d5 * d2 - d1 * d6;
      va = d3 * d6 - d5 * d4;
      e1 = d4 - d3; e2 = d5 - d6;
      kind = 1; st = a; dir = ab; num = 0; den = 0;
      if (d1 <= 0 && d2 <= 0) begin
        kind = 0; st = a;
      end else if (d3 >= 0 && d4 <= d3) begin
        kind = 0; st = b;
      end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
        st = a; dir = ab; num = d1; den = d1 - d3;
      end else if (d6 >= 0 && d5 <= d6) begin
        kind = 0; st = c;
      end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
        st = a; dir = ac; num = d2; den = d2 - d6;
      end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
        st = b; dir = bc; num = e1; den = e1 + e2;
      end else begin
        kind = 2; st = a; den = va + vb + vc;
      end
      // zero denominator falls back to the start vertex
      if (den == 0) kind = 0;
      for (int i = 0; i < 3; i++) begin
        if (kind == 0) r[i] = st[i];
        else if (kind == 1) r[i] = sat(st[i] + div_round(dir[i] * num, den));
        else r[i] = sat(a[i] + div_round(ab[i] * vb + ac[i] * vc, den));
      end
      o.near_x = r[0][CRD_W-1:0];
      o.near_y = r[1][CRD_W-1:0];
      o.near_z = r[2][CRD_W-1:0];
      return o;
    endfunction

    function void note(in_word_t w);
      pending = {pending, nearest(w)};
    endfunction

    function void check(out_word_t got);
      out_word_t want;
      n_checked++;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.near_x !== want.near_x || got.near_y !== want.near_y ||
          got.near_z !== want.near_z) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                   want.near_x, want.near_y, want.near_z,
                   got.near_x, got.near_y, got.near_z);
      end
    endfunction
  endclass

  localparam int ONE = 1 << 16;
  localparam int STALL_LIMIT = 5000;
  localparam int CRD_MAX = 32'h7fffffff;
  localparam int CRD_MIN = 32'h80000000;

  logic clk, rst_n, start, busy, out_strobe;
  in_word_t in_word;
  out_word_t out_word;
  nearest_point_board board;
  int unsigned n_sent, idle_pct, quiet;

  closest_point_on_triangle i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word),
    .busy(busy), .out_strobe(out_strobe), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check(out_word);
    if ((rst_n && start && !busy) || out_strobe) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("closest_point_on_triangle_tb failed");
      $finish;
    end
  end

  function automatic in_word_t mk(int px, int py, int pz, int ax, int ay, int az,
                                  int bx, int by, int bz, int cx, int cy, int cz);
    in_word_t w;
    w = '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
    return w;
  endfunction

  // one word, with a random gap ahead of it in the idling phases
  task automatic send(in_word_t w);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    board.note(w);
    n_sent++;
  endtask

  function automatic int coord(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int span, kind;
    kind = $urandom_range(9);
    span = kind < 5 ? 8 * ONE : (kind < 7 ? 32'h3fffffff : 300);
    w = '0;
    w = mk(coord(span), coord(span), coord(span), coord(span), coord(span),
           coord(span), coord(span), coord(span), coord(span), coord(span),
           coord(span), coord(span));
    if (kind == 7) w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (kind == 8) begin
      // degenerate shapes: coincident or collinear vertices
      if ($urandom_range(1)) {w.vert_b_x, w.vert_b_y, w.vert_b_z} =
                             {w.vert_a_x, w.vert_a_y, w.vert_a_z};
      else {w.vert_c_x, w.vert_c_y, w.vert_c_z} =
           {w.vert_b_x + (w.vert_b_x - w.vert_a_x), w.vert_b_y + (w.vert_b_y - w.vert_a_y),
            w.vert_b_z + (w.vert_b_z - w.vert_a_z)};
    end
    if (kind == 9) begin
      // near the range limits, so rounding and saturation get exercised
      w.vert_a_x = $urandom_range(1) ? CRD_MAX - coord(4) - 4 : CRD_MIN + coord(4) + 4;
      w.vert_b_x = $urandom_range(1) ? CRD_MAX : CRD_MIN;
      w.query_x  = $urandom;
    end
    return w;
  endfunction

  initial begin
    board   = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    quiet   = 0;
    n_sent  = 0;
    idle_pct = 23;
    repeat (12) @(posedge clk);
    rst_n <= 1'b0 ^ 1'b1;

    // directed: triangle a=(0,0,0) b=(4,0,0) c=(0,4,0), points in each region
    send(mk(-ONE, -ONE, ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));        // vertex a
    send(mk(6*ONE, -ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));         // vertex b
    send(mk(-ONE, 6*ONE, 3, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));         // vertex c
    send(mk(2*ONE, -3*ONE, 5, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));       // edge ab
    send(mk(-3*ONE, ONE+7, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));       // edge ac
    send(mk(3*ONE, 3*ONE, ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));      // edge bc
    send(mk(ONE, ONE+3, 9*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));      // face
    send(mk(1, 1, 1, 0, 0, 0, 3, 0, 0, 0, 3, 0));                        // face, odd ratios
    send(mk(5, 7, 2, 9, 9, 9, 9, 9, 9, 9, 9, 9));                        // all vertices equal
    send(mk(ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 3*ONE, 0, 0));                // zero-length ab
    send(mk(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0));              // collinear
    send(mk(ONE, 5, 0, 0, 0, 0, 2*ONE, 0, 0, 2*ONE, 0, 0));              // b equals c
    send(mk(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX,
            CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX));
    send(mk(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN,
            CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN));
    send(mk(CRD_MAX, CRD_MIN, 0, CRD_MIN, CRD_MIN, CRD_MIN,
            CRD_MAX, CRD_MIN, CRD_MAX, CRD_MIN, CRD_MAX, CRD_MAX));
    send(mk(CRD_MIN, CRD_MAX, CRD_MIN, CRD_MAX, CRD_MAX, 0,
            CRD_MIN, 0, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN));
    send(mk(0, 0, 0, CRD_MAX - 1, 0, 0, CRD_MAX, 1, 0, CRD_MAX, 0, 1));   // rounding at max
    send(mk(0, 0, 0, CRD_MIN + 1, 0, 0, CRD_MIN, 1, 0, CRD_MIN, 0, 1));   // rounding at min
    send(mk(-1, -1, -1, 0, 0, 0, -1, 0, 0, 0, -1, 0));

    for (int i = 0; i < 1800; i++) begin
      if (i == 600) idle_pct = 53;
      if (i == 1200) idle_pct = 0;
      send(random_word());
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (CPT_LAT + 10) @(posedge clk);
    $display("%0d point/triangle words sent, %0d results checked, %0d bad",
             n_sent, board.n_checked, board.n_bad);
    $display("covered every region, degenerate shapes and saturation at both limits");
    if (board.n_bad == 0 && board.pending.size() == 0)
      $display("closest_point_on_triangle_tb passed");
    else
      $display("closest_point_on_triangle_tb failed");
    $finish;
  end
endmodule
